// ===== hdl/owbm_pkg.sv =====
// ----------------------------------------------------------------------------
// owbm_pkg
// Shared types and constants for the 1-Wire byte master: command codes,
// bus phase codes, register indexes and the records passed between units.
// ----------------------------------------------------------------------------
package owbm_pkg;

  localparam int CMD_W     = 2;
  localparam int BYTE_W    = 8;
  localparam int CFG_W     = 10;
  localparam int CFG_IDX_W = 3;
  localparam int NUM_CFG   = 7;
  localparam int PHASE_W   = 3;
  localparam int BIT_IDX_W = 3;

  // command / active operation codes
  localparam logic [CMD_W-1:0] OP_NONE  = 2'd0;
  localparam logic [CMD_W-1:0] OP_RESET = 2'd1;
  localparam logic [CMD_W-1:0] OP_WRITE = 2'd2;
  localparam logic [CMD_W-1:0] OP_READ  = 2'd3;

  // bus phase codes
  localparam logic [PHASE_W-1:0] PH_IDLE       = 3'd0;
  localparam logic [PHASE_W-1:0] PH_RST_LOW    = 3'd1;
  localparam logic [PHASE_W-1:0] PH_RST_REL    = 3'd2;
  localparam logic [PHASE_W-1:0] PH_SHORT_LOW  = 3'd3;
  localparam logic [PHASE_W-1:0] PH_ZERO_LOW   = 3'd4;
  localparam logic [PHASE_W-1:0] PH_READ_REL   = 3'd5;
  localparam logic [PHASE_W-1:0] PH_READ_RECOV = 3'd6;
  localparam logic [PHASE_W-1:0] PH_ONE_REL    = 3'd7;

  // register indexes
  localparam int CFG_RST_LOW    = 0;
  localparam int CFG_RST_REL    = 1;
  localparam int CFG_SLOT_LOW   = 2;
  localparam int CFG_SAMPLE_DLY = 3;
  localparam int CFG_RECOVERY   = 4;
  localparam int CFG_ONE_REL    = 5;
  localparam int CFG_ZERO_LOW   = 6;

  localparam logic [CFG_W-1:0] CFG_RST_LOW_DEF    = 10'd500;
  localparam logic [CFG_W-1:0] CFG_RST_REL_DEF    = 10'd500;
  localparam logic [CFG_W-1:0] CFG_SLOT_LOW_DEF   = 10'd5;
  localparam logic [CFG_W-1:0] CFG_SAMPLE_DLY_DEF = 10'd5;
  localparam logic [CFG_W-1:0] CFG_RECOVERY_DEF   = 10'd50;
  localparam logic [CFG_W-1:0] CFG_ONE_REL_DEF    = 10'd60;
  localparam logic [CFG_W-1:0] CFG_ZERO_LOW_DEF   = 10'd60;

  typedef logic [NUM_CFG-1:0][CFG_W-1:0] owbm_cfg_t;

  // classified tick as it sits in the queue
  typedef struct packed {
    logic              is_cmd;
    logic [CMD_W-1:0]  op;
    logic [BYTE_W-1:0] wdata;
    logic              bus;
  } owbm_item_t;

  typedef struct packed {
    logic              drive_low;
    logic              busy;
    logic              done;
    logic [BYTE_W-1:0] read_data;
    logic              rejected;
  } owbm_res_t;

endpackage

// ===== hdl/owbm_front.sv =====
// ----------------------------------------------------------------------------
// owbm_front
// Input side: takes one tick per transfer, decodes the command and pushes
// the classified tick into the queue; stalls while the queue is full.
// ----------------------------------------------------------------------------
module owbm_front
  import owbm_pkg::*;
(
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  logic [CMD_W-1:0]  command_i,
  input  logic [BYTE_W-1:0] write_data_i,
  input  logic              bus_level_i,
  input  logic              q_full_i,
  output logic              q_push_o,
  output owbm_item_t        q_item_o
);

  assign in_stall_o = q_full_i;
  assign q_push_o   = in_valid_i & ~q_full_i;

  always_comb begin
    q_item_o        = '0;
    q_item_o.is_cmd = (command_i != OP_NONE);
    q_item_o.op     = command_i;
    // only a write carries its byte forward
    q_item_o.wdata  = (command_i == OP_WRITE) ? write_data_i : '0;
    q_item_o.bus    = bus_level_i;
  end

endmodule

// ===== hdl/owbm_queue.sv =====
// ----------------------------------------------------------------------------
// owbm_queue
// Short flip-flop queue between the input decode and the bus sequencer.
// ----------------------------------------------------------------------------
module owbm_queue
  import owbm_pkg::*;
#(
  parameter int DEPTH = 2
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       push_i,
  input  owbm_item_t item_i,
  output logic       full_o,
  input  logic       pop_i,
  output logic       valid_o,
  output owbm_item_t item_o
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] LAST = PW'(DEPTH - 1);

  owbm_item_t [DEPTH-1:0] mem_q;
  logic [PW-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CW-1:0] count_q, count_d;
  logic          do_push, do_pop;

  assign full_o  = (count_q == CW'(DEPTH));
  assign valid_o = (count_q != '0);
  assign item_o  = mem_q[rd_ptr_q];
  assign do_push = push_i & ~full_o;
  assign do_pop  = pop_i & valid_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == LAST) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == LAST) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_d = count_q + 1'b1;
    end else if (do_pop && !do_push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= item_i;
    end
  end

endmodule

// ===== hdl/owbm_back.sv =====
// ----------------------------------------------------------------------------
// owbm_back
// Bus sequencer: runs the reset, write and read slot phases one tick per
// queued item and holds each tick's result in an output register.
// ----------------------------------------------------------------------------
module owbm_back
  import owbm_pkg::*;
#(
  parameter int TIME_BITS = 10
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  owbm_cfg_t  cfg_i,
  input  logic       q_valid_i,
  input  owbm_item_t q_item_i,
  output logic       q_pop_o,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output owbm_res_t  res_o
);

  localparam int LW = 17;
  localparam logic [LW-1:0] TMAX = LW'((2 ** TIME_BITS) - 1);

  logic [PHASE_W-1:0]   phase_q, phase_d;
  logic [TIME_BITS-1:0] timer_q, timer_d;
  logic [BIT_IDX_W-1:0] bit_q, bit_d;
  logic [BYTE_W-1:0]    sb_q, sb_d;
  logic [CMD_W-1:0]     op_q, op_d;
  logic                 out_valid_q, out_valid_d;
  owbm_res_t            res_q, res_d;
  logic [LW-1:0]        len, tick_cnt;
  logic                 last, slot_end, finish;

  function automatic logic [LW-1:0] phase_len(input logic [PHASE_W-1:0] ph,
                                               input owbm_cfg_t c);
    logic [LW-1:0] v;
    case (ph)
      PH_RST_LOW:    v = LW'(c[CFG_RST_LOW]);
      PH_RST_REL:    v = LW'(c[CFG_RST_REL]);
      PH_SHORT_LOW:  v = LW'(c[CFG_SLOT_LOW]);
      PH_READ_REL:   v = LW'(c[CFG_SAMPLE_DLY]);
      PH_READ_RECOV: v = LW'(c[CFG_RECOVERY]);
      PH_ONE_REL:    v = LW'(c[CFG_ONE_REL]);
      PH_ZERO_LOW:   v = LW'(c[CFG_ZERO_LOW]);
      default:       v = LW'(1);
    endcase
    if (v == '0) begin
      v = LW'(1);
    end
    if (v > TMAX) begin
      v = TMAX;
    end
    return v;
  endfunction

  assign q_pop_o     = q_valid_i & (~out_valid_q | ~out_stall_i);
  assign out_valid_o = out_valid_q;
  assign res_o       = res_q;

  always_comb begin
    phase_d     = phase_q;
    timer_d     = timer_q;
    bit_d       = bit_q;
    sb_d        = sb_q;
    op_d        = op_q;
    res_d       = res_q;
    len         = '0;
    tick_cnt    = '0;
    last        = 1'b0;
    slot_end    = 1'b0;
    finish      = 1'b0;
    out_valid_d = out_valid_q & out_stall_i;

    if (q_pop_o) begin
      out_valid_d = 1'b1;
      res_d       = '0;
      if (phase_q == PH_IDLE) begin
        if (q_item_i.is_cmd) begin
          op_d    = q_item_i.op;
          bit_d   = '0;
          timer_d = '0;
          if (q_item_i.op == OP_RESET) begin
            phase_d = PH_RST_LOW;
          end else begin
            sb_d    = q_item_i.wdata;
            phase_d = (q_item_i.op == OP_WRITE && !q_item_i.wdata[0]) ?
                      PH_ZERO_LOW : PH_SHORT_LOW;
          end
        end
      end else if (q_item_i.is_cmd) begin
        res_d.rejected = 1'b1;
      end

      if (phase_d != PH_IDLE) begin
        res_d.busy      = 1'b1;
        res_d.drive_low = (phase_d == PH_RST_LOW) || (phase_d == PH_SHORT_LOW) ||
                          (phase_d == PH_ZERO_LOW);
        // sample on the first recovery tick
        if (phase_d == PH_READ_RECOV && timer_d == '0) begin
          sb_d = {q_item_i.bus, sb_d[BYTE_W-1:1]};
        end
        len      = phase_len(phase_d, cfg_i);
        tick_cnt = LW'(timer_d) + LW'(1);
        last     = (tick_cnt >= len);
        if (!last) begin
          timer_d = TIME_BITS'(tick_cnt);
        end else begin
          timer_d = '0;
          case (phase_d)
            PH_RST_LOW:   phase_d = PH_RST_REL;
            PH_RST_REL:   finish = 1'b1;
            PH_SHORT_LOW: phase_d = (op_d == OP_READ) ? PH_READ_REL : PH_ONE_REL;
            PH_READ_REL:  phase_d = PH_READ_RECOV;
            default:      slot_end = 1'b1;
          endcase
          if (slot_end) begin
            if (bit_d == '1) begin
              finish = 1'b1;
            end else begin
              bit_d = bit_d + 1'b1;
              if (op_d == OP_WRITE) begin
                sb_d    = sb_d >> 1;
                phase_d = sb_d[0] ? PH_SHORT_LOW : PH_ZERO_LOW;
              end else begin
                phase_d = PH_SHORT_LOW;
              end
            end
          end
          if (finish) begin
            res_d.done = 1'b1;
            if (op_d == OP_READ) begin
              res_d.read_data = sb_d;
            end
            phase_d = PH_IDLE;
            op_d    = OP_NONE;
            bit_d   = '0;
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_IDLE;
      timer_q     <= '0;
      bit_q       <= '0;
      sb_q        <= '0;
      op_q        <= OP_NONE;
      out_valid_q <= 1'b0;
    end else begin
      phase_q     <= phase_d;
      timer_q     <= timer_d;
      bit_q       <= bit_d;
      sb_q        <= sb_d;
      op_q        <= op_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
  end

endmodule

// ===== hdl/one_wire_byte_master.sv =====
// An accepted tick passes the queue, then the sequencer's output register.
// Throughput: one tick per cycle; the sequencer retires one queued tick per
// cycle whenever the output register is free or being taken.
// The two-entry queue and output register absorb output stalls.
// Reset (rst_ni low, asynchronous): bus idle, queue empty, no result pending,
// timing registers back to their defaults.
// ----------------------------------------------------------------------------
// one_wire_byte_master
// 1-Wire bus master stepped one microsecond tick per transfer, with reset,
// write-byte and read-byte commands and a register port for slot timing.
// ----------------------------------------------------------------------------
module one_wire_byte_master
  import owbm_pkg::*;
#(
  parameter int TIME_BITS = 10
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  logic [CMD_W-1:0]     command_i,
  input  logic [BYTE_W-1:0]    write_data_i,
  input  logic                 bus_level_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output logic                 drive_low_o,
  output logic                 busy_res_o,
  output logic                 done_res_o,
  output logic [BYTE_W-1:0]    read_data_o,
  output logic                 rejected_o,
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [CFG_W-1:0]     cfg_data_i
);

  owbm_cfg_t  cfg_q;
  owbm_item_t push_item, pop_item;
  owbm_res_t  res;
  logic       q_push, q_full, q_pop, q_valid;

  assign cfg_ready_o = 1'b1;

  // indexes past the last register are dropped
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q[CFG_RST_LOW]    <= CFG_RST_LOW_DEF;
      cfg_q[CFG_RST_REL]    <= CFG_RST_REL_DEF;
      cfg_q[CFG_SLOT_LOW]   <= CFG_SLOT_LOW_DEF;
      cfg_q[CFG_SAMPLE_DLY] <= CFG_SAMPLE_DLY_DEF;
      cfg_q[CFG_RECOVERY]   <= CFG_RECOVERY_DEF;
      cfg_q[CFG_ONE_REL]    <= CFG_ONE_REL_DEF;
      cfg_q[CFG_ZERO_LOW]   <= CFG_ZERO_LOW_DEF;
    end else if (cfg_valid_i && cfg_ready_o && (cfg_index_i < CFG_IDX_W'(NUM_CFG))) begin
      cfg_q[cfg_index_i] <= cfg_data_i;
    end
  end

  owbm_front u_front (
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .command_i    (command_i),
    .write_data_i (write_data_i),
    .bus_level_i  (bus_level_i),
    .q_full_i     (q_full),
    .q_push_o     (q_push),
    .q_item_o     (push_item)
  );

  owbm_queue #(
    .DEPTH (2)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .item_i  (push_item),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .valid_o (q_valid),
    .item_o  (pop_item)
  );

  owbm_back #(
    .TIME_BITS (TIME_BITS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .q_valid_i   (q_valid),
    .q_item_i    (pop_item),
    .q_pop_o     (q_pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .res_o       (res)
  );

  assign drive_low_o = res.drive_low;
  assign busy_res_o  = res.busy;
  assign done_res_o  = res.done;
  assign read_data_o = res.read_data;
  assign rejected_o  = res.rejected;

endmodule

// ===== hdl/owbm_checker.sv =====
// ----------------------------------------------------------------------------
// owbm_checker
// Port-level checks on the 1-Wire byte master's result stream.
// ----------------------------------------------------------------------------
module owbm_checker
  import owbm_pkg::*;
(
  input logic              clk_i,
  input logic              rst_ni,
  input logic              out_valid_o,
  input logic              out_stall_i,
  input logic              drive_low_o,
  input logic              busy_res_o,
  input logic              done_res_o,
  input logic [BYTE_W-1:0] read_data_o,
  input logic              rejected_o
);

  // a stalled result holds until taken
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(drive_low_o) &&
      $stable(busy_res_o) && $stable(done_res_o) && $stable(read_data_o) &&
      $stable(rejected_o))
    else $error("stalled result changed");

  a_done_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && done_res_o |-> busy_res_o)
    else $error("done without busy");

  a_drive_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && drive_low_o |-> busy_res_o)
    else $error("line driven while idle");

  a_rej_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && rejected_o |-> busy_res_o)
    else $error("command rejected while idle");

  // read byte only shows on a completing transfer
  a_rdata_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (read_data_o != '0) |-> done_res_o)
    else $error("read data outside done");

endmodule

bind one_wire_byte_master owbm_checker u_owbm_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .drive_low_o (drive_low_o),
  .busy_res_o  (busy_res_o),
  .done_res_o  (done_res_o),
  .read_data_o (read_data_o),
  .rejected_o  (rejected_o)
);

// ===== bench/one_wire_byte_master_test.sv =====
// ----------------------------------------------------------------------------
// one_wire_byte_master_test
// Self-checking bench for the 1-Wire byte master: every tick transfer is run
// through an exact tick-by-tick model of the bus sequencer, and each output transfer
// is compared field by field, under several slot timing sets and random
// handshake gaps on both sides.
// ----------------------------------------------------------------------------
import owbm_pkg::*;

class bus_tick_scoreboard;
  logic [CFG_W-1:0]     timing [NUM_CFG];
  logic [PHASE_W-1:0]   ph;
  logic [CFG_W-1:0]     elapsed;
  logic [BIT_IDX_W-1:0] slot_bit;
  logic [BYTE_W-1:0]    shreg;
  logic [CMD_W-1:0]     cur_op;
  owbm_res_t            due_results [$];
  int errors, n_ticks, n_done, n_reads, n_rejected;

  function void init();
    timing[CFG_RST_LOW]    = CFG_RST_LOW_DEF;
    timing[CFG_RST_REL]    = CFG_RST_REL_DEF;
    timing[CFG_SLOT_LOW]   = CFG_SLOT_LOW_DEF;
    timing[CFG_SAMPLE_DLY] = CFG_SAMPLE_DLY_DEF;
    timing[CFG_RECOVERY]   = CFG_RECOVERY_DEF;
    timing[CFG_ONE_REL]    = CFG_ONE_REL_DEF;
    timing[CFG_ZERO_LOW]   = CFG_ZERO_LOW_DEF;
    ph       = PH_IDLE;
    elapsed  = '0;
    slot_bit = '0;
    shreg    = '0;
    cur_op   = OP_NONE;
  endfunction

  function void write_reg(int idx, logic [CFG_W-1:0] val);
    if (idx < NUM_CFG) timing[idx] = val;
  endfunction

  // length of a phase in ticks; zero behaves as one
  function int span(logic [PHASE_W-1:0] p);
    int v;
    case (p)
      PH_RST_LOW:    v = timing[CFG_RST_LOW];
      PH_RST_REL:    v = timing[CFG_RST_REL];
      PH_SHORT_LOW:  v = timing[CFG_SLOT_LOW];
      PH_READ_REL:   v = timing[CFG_SAMPLE_DLY];
      PH_READ_RECOV: v = timing[CFG_RECOVERY];
      PH_ONE_REL:    v = timing[CFG_ONE_REL];
      PH_ZERO_LOW:   v = timing[CFG_ZERO_LOW];
      default:       v = 1;
    endcase
    if (v == 0) v = 1;
    return v;
  endfunction

  function void start_slot();
    elapsed = '0;
    if (cur_op == OP_WRITE && !shreg[0]) ph = PH_ZERO_LOW;
    else ph = PH_SHORT_LOW;
  endfunction

  function bit idle();
    return ph == PH_IDLE;
  endfunction

  function int pending();
    return due_results.size();
  endfunction

  // advance the bus sequencer by one tick and queue what it should report
  function void note_tick(logic [CMD_W-1:0] cmd, logic [BYTE_W-1:0] wd, logic bus);
    owbm_res_t r;
    bit finish;
    bit slot_end;
    r = '0;
    n_ticks++;
    if (ph == PH_IDLE) begin
      if (cmd != OP_NONE) begin
        cur_op   = cmd;
        slot_bit = '0;
        elapsed  = '0;
        if (cmd == OP_RESET) begin
          ph = PH_RST_LOW;
        end else begin
          shreg = (cmd == OP_WRITE) ? wd : '0;
          start_slot();
        end
      end
    end else if (cmd != OP_NONE) begin
      r.rejected = 1'b1;
      n_rejected++;
    end
    if (ph != PH_IDLE) begin
      r.busy      = 1'b1;
      r.drive_low = (ph == PH_RST_LOW) || (ph == PH_SHORT_LOW) || (ph == PH_ZERO_LOW);
      // the first recovery tick is the sample point
      if (ph == PH_READ_RECOV && elapsed == '0) shreg = {bus, shreg[BYTE_W-1:1]};
      if (int'(elapsed) + 1 < span(ph)) begin
        elapsed++;
      end else begin
        finish   = 1'b0;
        slot_end = 1'b0;
        elapsed  = '0;
        case (ph)
          PH_RST_LOW:   ph = PH_RST_REL;
          PH_RST_REL:   finish = 1'b1;
          PH_SHORT_LOW: ph = (cur_op == OP_READ) ? PH_READ_REL : PH_ONE_REL;
          PH_READ_REL:  ph = PH_READ_RECOV;
          default:      slot_end = 1'b1;
        endcase
        if (slot_end) begin
          if (&slot_bit) begin
            finish = 1'b1;
          end else begin
            slot_bit++;
            if (cur_op == OP_WRITE) shreg = shreg >> 1;
            start_slot();
          end
        end
        if (finish) begin
          r.done = 1'b1;
          n_done++;
          if (cur_op == OP_READ) begin
            r.read_data = shreg;
            n_reads++;
          end
          ph       = PH_IDLE;
          cur_op   = OP_NONE;
          slot_bit = '0;
        end
      end
    end
    due_results.push_back(r);
  endfunction

  function void compare_field(string name, int want, int seen);
    if (want != seen) begin
      errors++;
      $display("%0t: %s expected %0h, got %0h", $time, name, want, seen);
    end
  endfunction

  function void check_result(owbm_res_t seen);
    owbm_res_t want;
    if (due_results.size() == 0) begin
      errors++;
      $display("%0t: output transfer with nothing expected, got %h", $time, seen);
      return;
    end
    want = due_results.pop_front();
    compare_field("drive_low", want.drive_low, seen.drive_low);
    compare_field("busy", want.busy, seen.busy);
    compare_field("done", want.done, seen.done);
    compare_field("read_data", want.read_data, seen.read_data);
    compare_field("rejected", want.rejected, seen.rejected);
  endfunction
endclass

module one_wire_byte_master_test;

  localparam int LIMIT          = 400000;
  localparam int HOLD_CYCLES    = 200;
  localparam int DRAIN_CYCLES   = 4;
  localparam int PHASE_TICKS    = 165;
  localparam int NUM_PHASES     = 8;

  typedef enum {TIMING_ZERO, TIMING_MIN, TIMING_SMALL, TIMING_MAX, TIMING_MIXED} timing_mode_e;

  logic                 clk_i;
  logic                 rst_ni;
  logic                 in_valid_i;
  logic                 in_stall_o;
  logic [CMD_W-1:0]     command_i;
  logic [BYTE_W-1:0]    write_data_i;
  logic                 bus_level_i;
  logic                 out_valid_o;
  logic                 out_stall_i;
  logic                 drive_low_o;
  logic                 busy_res_o;
  logic                 done_res_o;
  logic [BYTE_W-1:0]    read_data_o;
  logic                 rejected_o;
  logic                 cfg_valid_i;
  logic                 cfg_ready_o;
  logic [CFG_IDX_W-1:0] cfg_index_i;
  logic [CFG_W-1:0]     cfg_data_i;

  bus_tick_scoreboard sb;
  int cycles = 0;
  bit hold_req = 1'b0;
  bit no_gaps = 1'b0;

  timing_mode_e phase_plan [NUM_PHASES] = '{TIMING_MIXED, TIMING_MIN, TIMING_SMALL, TIMING_MAX,
                                            TIMING_ZERO, TIMING_MIXED, TIMING_SMALL, TIMING_MIXED};

  one_wire_byte_master DUT (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .command_i    (command_i),
    .write_data_i (write_data_i),
    .bus_level_i  (bus_level_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .drive_low_o  (drive_low_o),
    .busy_res_o   (busy_res_o),
    .done_res_o   (done_res_o),
    .read_data_o  (read_data_o),
    .rejected_o   (rejected_o),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycles, sb.pending());
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  always @(posedge clk_i) begin : monitor
    owbm_res_t seen;
    seen.drive_low = drive_low_o;
    seen.busy      = busy_res_o;
    seen.done      = done_res_o;
    seen.read_data = read_data_o;
    seen.rejected  = rejected_o;
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) sb.note_tick(command_i, write_data_i, bus_level_i);
      if (out_valid_o && !out_stall_i) sb.check_result(seen);
    end
  end

  // output side: random stall before each transfer, one long hold on request
  initial begin
    int n;
    out_stall_i <= 1'b0;
    @(posedge rst_ni);
    @(negedge clk_i);
    forever begin
      if (hold_req) begin
        n = HOLD_CYCLES;
        hold_req = 1'b0;
      end else begin
        n = no_gaps ? 0 : $urandom_range(0, 10);
      end
      if (n > 0) begin
        out_stall_i <= 1'b1;
        repeat (n) @(negedge clk_i);
      end
      out_stall_i <= 1'b0;
      do @(posedge clk_i); while (!out_valid_o);
      @(negedge clk_i);
    end
  end

  task automatic send_tick(logic [CMD_W-1:0] cmd, logic [BYTE_W-1:0] wd, logic bus);
    int gap;
    gap = no_gaps ? 0 : $urandom_range(0, 10);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i   <= 1'b1;
    command_i    <= cmd;
    write_data_i <= wd;
    bus_level_i  <= bus;
    do @(posedge clk_i); while (in_stall_o);
    @(negedge clk_i);
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    while (sb.pending() != 0) @(negedge clk_i);
    repeat (DRAIN_CYCLES) @(negedge clk_i);
  endtask

  task automatic cfg_write(int idx, logic [CFG_W-1:0] val);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= CFG_IDX_W'(idx);
    cfg_data_i  <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    sb.write_reg(idx, val);
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
    @(negedge clk_i);
  endtask

  // the index past the last register is written too and must be ignored
  task automatic load_timing(timing_mode_e mode);
    logic [CFG_W-1:0] v;
    for (int i = 0; i <= NUM_CFG; i++) begin
      case (mode)
        TIMING_ZERO:  v = '0;
        TIMING_MIN:   v = CFG_W'(1);
        TIMING_SMALL: v = CFG_W'($urandom_range(0, 4));
        TIMING_MAX:   v = '1;
        default:      v = ($urandom_range(0, 9) == 0) ? CFG_W'($urandom_range(10, 30))
                                                       : CFG_W'($urandom_range(1, 5));
      endcase
      cfg_write(i, v);
    end
  endtask

  // start a command, poke once while it runs, then tick until it finishes
  task automatic run_cmd(logic [CMD_W-1:0] cmd, logic [BYTE_W-1:0] wd, logic bus,
                         logic [CMD_W-1:0] poke);
    send_tick(cmd, wd, bus);
    if (!sb.idle()) send_tick(poke, ~wd, bus);
    while (!sb.idle()) send_tick(OP_NONE, BYTE_W'($urandom), bus);
  endtask

  task automatic random_tick();
    int r;
    logic [CMD_W-1:0] cmd;
    r = $urandom_range(0, 99);
    if (r < 5) cmd = CMD_W'($urandom);
    else if (sb.idle()) cmd = (r < 45) ? CMD_W'($urandom_range(OP_RESET, OP_READ)) : OP_NONE;
    else cmd = (r < 12) ? CMD_W'($urandom_range(OP_RESET, OP_READ)) : OP_NONE;
    send_tick(cmd, BYTE_W'($urandom), 1'($urandom_range(0, 1)));
  endtask

  initial begin
    sb = new;
    sb.init();
    rst_ni       <= 1'b0;
    in_valid_i   <= 1'b0;
    command_i    <= OP_NONE;
    write_data_i <= '0;
    bus_level_i  <= 1'b0;
    cfg_valid_i  <= 1'b0;
    cfg_index_i  <= '0;
    cfg_data_i   <= '0;
    repeat (4) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // directed: zero timing acts as one tick per phase
    load_timing(TIMING_ZERO);
    send_tick(OP_NONE, 8'hFF, 1'b1);
    run_cmd(OP_RESET, 8'h00, 1'b0, OP_WRITE);
    run_cmd(OP_WRITE, 8'hFF, 1'b1, OP_NONE);
    run_cmd(OP_WRITE, 8'h00, 1'b0, OP_READ);
    run_cmd(OP_READ, 8'h5A, 1'b1, OP_RESET);
    drain();

    for (int p = 0; p < NUM_PHASES; p++) begin
      load_timing(phase_plan[p]);
      no_gaps = (p == 1) || (p == 5);
      if (p == 2) hold_req = 1'b1;
      repeat (PHASE_TICKS) random_tick();
      // idle handoff: settle all results before touching the registers
      drain();
    end

    $display("ran %0d ticks: %0d commands completed (%0d reads), %0d rejected",
             sb.n_ticks, sb.n_done, sb.n_reads, sb.n_rejected);
    $display("timing sets zero, minimum, small, maximum, mixed; one long output hold");
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

// ===== files.f =====
hdl/owbm_pkg.sv
hdl/owbm_front.sv
hdl/owbm_queue.sv
hdl/owbm_back.sv
hdl/one_wire_byte_master.sv
hdl/owbm_checker.sv
bench/one_wire_byte_master_test.sv
